@@ src/float_multiply_truncating_unit_macros.svh @@
// Assertion macros for the truncating multiplier.
`ifndef FLOAT_MULTIPLY_TRUNCATING_UNIT_MACROS_SVH
`define FLOAT_MULTIPLY_TRUNCATING_UNIT_MACROS_SVH
`define FMT_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define FMT_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

@@ src/fmt_pkg.sv @@
`default_nettype none
package fmt_pkg;
  localparam int unsigned FracW = 23;
  localparam int unsigned ExpW = 8;
  localparam logic [9:0] SubLimit = 10'd128;
  localparam logic [9:0] OvfLimit = 10'd381;
  localparam logic [9:0] Bias = 10'd127;
  localparam logic [7:0] ExpInf = 8'hff;
  typedef struct packed {
    logic sign;
    logic zero;
    logic [8:0] esum;
  } ctl_t;
endpackage
`default_nettype wire

@@ src/float_multiply_truncating_unit.sv @@
// Channel | Ports                                        | Direction
// in      | in_valid, in_ready, in_multiplicand, in_multiplier | request into the unit
// out     | out_valid, out_ready, out_product            | result from the unit
// One request may enter every cycle unless all stages are full and stalled.
// The 24x24 significand multiply is split into two 24x12 halves in stage one
// and summed in stage two, which set the stage depth.
// Reset clears only the stage valid bits. When out_ready is low, a held result
// stalls each full stage behind it; a request is still taken while any stage is empty.
`default_nettype none
`include "float_multiply_truncating_unit_macros.svh"
module float_multiply_truncating_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_multiplicand,
  input  wire logic [31:0] in_multiplier,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_product
);
  import fmt_pkg::*;

  logic [3:0] v_r, v_nxt;
  logic [3:0] adv;
  fmt_pkg::ctl_t c1_r, c2_r, c3_r, c1_nxt;
  logic [35:0] plo_r, phi_r;
  logic [47:0] prod_r, prod_nxt;
  logic [22:0] frac_r, frac_nxt;
  logic [9:0] biased_r, biased_nxt;
  logic [31:0] out_r, out_nxt;
  logic [7:0] ea, eb;
  logic [23:0] sa, sb;
  logic [4:0] sh;
  logic [23:0] full;
  logic [9:0] shd;

  assign adv[3] = !v_r[3] || out_ready;
  assign adv[2] = !v_r[2] || adv[3];
  assign adv[1] = !v_r[1] || adv[2];
  assign adv[0] = !v_r[0] || adv[1];
  assign in_ready = adv[0];
  assign out_valid = v_r[3];
  assign out_product = out_r;

  always_comb begin
    ea = in_multiplicand[30:23];
    eb = in_multiplier[30:23];
    sa = {ea != 8'd0, in_multiplicand[22:0]};
    sb = {eb != 8'd0, in_multiplier[22:0]};
    c1_nxt.sign = in_multiplicand[31] ^ in_multiplier[31];
    c1_nxt.zero = (ea == 8'd0) || (eb == 8'd0 && in_multiplier[22:21] == 2'd0);
    c1_nxt.esum = {1'b0, (ea == 8'd0) ? 8'd1 : ea} + {1'b0, (eb == 8'd0) ? 8'd1 : eb};
  end

  always_comb begin
    prod_nxt = {12'd0, plo_r} + {phi_r, 12'd0};
  end

  always_comb begin
    if (prod_r[47]) begin
      frac_nxt = prod_r[46:24];
      biased_nxt = {1'b0, c2_r.esum} + 10'd1;
    end else if (prod_r[46]) begin
      frac_nxt = prod_r[45:23];
      biased_nxt = {1'b0, c2_r.esum};
    end else if (prod_r[45]) begin
      frac_nxt = prod_r[44:22];
      biased_nxt = {1'b0, c2_r.esum} - 10'd1;
    end else if (prod_r[44]) begin
      frac_nxt = prod_r[43:21];
      biased_nxt = {1'b0, c2_r.esum} - 10'd2;
    end else begin
      frac_nxt = '0;
      biased_nxt = '0;
    end
  end

  always_comb begin
    shd = SubLimit - biased_r;
    sh = shd[4:0];
    full = {1'b1, frac_r};
    if (c3_r.zero) begin
      out_nxt = {c3_r.sign, 31'd0};
    end else if (biased_r < SubLimit) begin
      out_nxt = {c3_r.sign, 8'd0, (shd >= 10'd24) ? 23'd0 : 23'(full >> sh)};
    end else if (biased_r > OvfLimit) begin
      out_nxt = {c3_r.sign, ExpInf, 23'd0};
    end else begin
      out_nxt = {c3_r.sign, 8'(biased_r - Bias), frac_r};
    end
  end

  always_comb begin
    v_nxt[0] = adv[0] ? in_valid : v_r[0];
    v_nxt[1] = adv[1] ? v_r[0] : v_r[1];
    v_nxt[2] = adv[2] ? v_r[1] : v_r[2];
    v_nxt[3] = adv[3] ? v_r[2] : v_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      c1_r <= c1_nxt;
      plo_r <= {12'd0, sa} * {24'd0, sb[11:0]};
      phi_r <= {12'd0, sa} * {24'd0, sb[23:12]};
    end
    if (adv[1]) begin
      c2_r <= c1_r;
      prod_r <= prod_nxt;
    end
    if (adv[2]) begin
      c3_r <= c2_r;
      frac_r <= frac_nxt;
      biased_r <= biased_nxt;
    end
    if (adv[3]) begin
      out_r <= out_nxt;
    end
  end

  `FMT_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_product), "result changed while stalled")
  `FMT_ASSERT_IMPL(a_ready, clk, rst_n, !in_ready, v_r == 4'hf, "input stalled with an empty stage")
  `FMT_ASSERT_NEXT(a_flow, clk, rst_n, v_r[2] && adv[3], v_r[3], "request lost at last stage")
endmodule
`default_nettype wire

@@ tb/sv/float_multiply_truncating_unit_test.sv @@
`timescale 1ns / 100ps
`default_nettype none

class product_scoreboard;
  logic [31:0] pending_products[$];
  int mismatches;
  int checked;

  function logic [31:0] truncated_product(logic [31:0] a, logic [31:0] b);
    logic [7:0] ea;
    logic [7:0] eb;
    logic [23:0] sa;
    logic [23:0] sb;
    logic [9:0] esum;
    logic [47:0] prod;
    logic [22:0] frac;
    logic [9:0] biased;
    logic [9:0] sh;
    logic [23:0] full;
    logic [7:0] eo;
    logic [22:0] fo;
    logic sgn;
    ea = a[30:23];
    eb = b[30:23];
    sgn = a[31] ^ b[31];
    sa = (ea == 0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
    sb = (eb == 0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
    esum = ((ea == 0) ? 10'd1 : {2'b0, ea}) + ((eb == 0) ? 10'd1 : {2'b0, eb});
    prod = {24'b0, sa} * {24'b0, sb};
    if (prod[47]) begin
      frac = prod[46:24];
      biased = esum + 10'd1;
    end else if (prod[46]) begin
      frac = prod[45:23];
      biased = esum;
    end else if (prod[45]) begin
      frac = prod[44:22];
      biased = esum - 10'd1;
    end else if (prod[44]) begin
      frac = prod[43:21];
      biased = esum - 10'd2;
    end else begin
      frac = '0;
      biased = '0;
    end
    if (ea == 0 || (eb == 0 && b[22:21] == 2'b00)) begin
      eo = '0;
      fo = '0;
    end else if (biased < fmt_pkg::SubLimit) begin
      sh = fmt_pkg::SubLimit - biased;
      full = {1'b1, frac};
      eo = '0;
      fo = (sh >= 24) ? '0 : 23'(full >> sh);
    end else if (biased > fmt_pkg::OvfLimit) begin
      eo = fmt_pkg::ExpInf;
      fo = '0;
    end else begin
      eo = 8'(biased - fmt_pkg::Bias);
      fo = frac;
    end
    return {sgn, eo, fo};
  endfunction

  function void note_request(logic [31:0] a, logic [31:0] b);
    pending_products.push_back(truncated_product(a, b));
  endfunction

  function void check_product(logic [31:0] actual);
    logic [31:0] want;
    checked++;
    if (pending_products.size() == 0) begin
      $display("%0t: unexpected product %h", $time, actual);
      mismatches++;
    end else begin
      want = pending_products.pop_front();
      if (want !== actual) begin
        $display("%0t: product expected %h actual %h", $time, want, actual);
        mismatches++;
      end
    end
  endfunction
endclass

module float_multiply_truncating_unit_test;
  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [31:0] in_multiplicand = '0;
  logic [31:0] in_multiplier = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [31:0] out_product;
  logic hold_off = 0;
  int sent;
  product_scoreboard board = new();

  float_multiply_truncating_unit dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_multiplicand(in_multiplicand), .in_multiplier(in_multiplier),
    .out_valid(out_valid), .out_ready(out_ready), .out_product(out_product)
  );

  always #4 clk = ~clk;

  function int gap_length();
    if ($urandom_range(9) < 6) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function logic [31:0] random_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(7))
      0: v[30:23] = 8'h00;
      1: v[30:23] = 8'hff;
      2: v[30:23] = 8'($urandom_range(140, 30));
      3: v[30:23] = 8'($urandom_range(4, 1));
      4: v[30:23] = 8'($urandom_range(254, 200));
      default: ;
    endcase
    if ($urandom_range(7) == 0) v[22:0] = ($urandom_range(1)) ? 23'h7fffff : 23'h0;
    return v;
  endfunction

  task automatic send_request(logic [31:0] a, logic [31:0] b, bit with_gaps);
    int gap;
    gap = with_gaps ? gap_length() : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_multiplicand <= a;
    in_multiplier <= b;
    do @(posedge clk); while (!in_ready);
    board.note_request(a, b);
    sent++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_product(out_product);
  end

  initial begin : receiver
    int g;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_ready <= 0;
        repeat (40) @(posedge clk);
        hold_off = 0;
      end
      g = (sent < 200) ? 0 : gap_length();
      if (g > 0) begin
        out_ready <= 0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
    end
  end

  initial begin : limit
    #20ms;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] edge_ops[10];
    int guard;
    edge_ops = '{32'h0, 32'h80000000, 32'h3f800000, 32'hbf800000, 32'h7f7fffff,
                 32'h7f800000, 32'h00000001, 32'h00600000, 32'h00200000, 32'hffffffff};
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int i = 0; i < 10; i++) send_request(edge_ops[i], edge_ops[(i * 3 + 1) % 10], 0);
    send_request(32'h00800000, 32'h00800000, 0);
    send_request(32'h3f000000, 32'h20000000, 0);
    send_request(32'h7f000000, 32'h7f000000, 0);
    send_request(32'h3fffffff, 32'h3fffffff, 0);
    send_request(32'h00400000, 32'h3f800000, 0);
    send_request(32'h3f800000, 32'h00400000, 0);
    hold_off = 1;
    for (int i = 0; i < 60; i++) send_request(random_operand(), random_operand(), 0);
    in_valid <= 0;
    guard = 0;
    while (board.pending_products.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    for (int i = 0; i < 1330; i++) begin
      send_request(random_operand(), random_operand(), i % 300 > 40);
    end
    in_valid <= 0;
    guard = 0;
    while (board.pending_products.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    $display("Sent %0d multiply requests, checked %0d products, %0d mismatches.",
             sent, board.checked, board.mismatches);
    if (board.mismatches == 0 && board.pending_products.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

`default_nettype wire

@@ files.f @@
+incdir+src
src/fmt_pkg.sv
src/float_multiply_truncating_unit.sv
tb/sv/float_multiply_truncating_unit_test.sv
